// ----- design/brce_pkg.sv -----
package brce_pkg;
	localparam logic [7:0] FMT_BINARY    = 8'h80;
	localparam logic [7:0] FMT_SIGN      = 8'h40;
	localparam logic [7:0] FMT_EXPLEN2   = 8'h01;
	localparam logic [7:0] OCT_PLUS_INF  = 8'h40;
	localparam logic [7:0] OCT_MINUS_INF = 8'h41;

	typedef enum logic [1:0] {
		K_NORMAL,
		K_ZERO,
		K_INF,
		K_NAN
	} kind_t;

	// classified request handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic        sign;
		logic [15:0] expo;
		logic        elen2;
		logic [3:0]  mlen;
		logic [63:0] mant;
	} job_t;

	// position of the leading one in a 52-bit fraction
	function automatic logic [5:0] lead_pos(input logic [51:0] v);
		logic [5:0] p;
		p = 6'd0;
		for (int i = 0; i < 52; i++) begin
			if (v[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction
endpackage

// ----- design/brce_front.sv -----
module brce_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [63:0]   value_bits,
	output logic          job_valid,
	input  logic          job_ready,
	output brce_pkg::job_t job
);
	import brce_pkg::*;

	// stage 1 registers raw fields and leading-one position
	logic        v_s1;
	logic        sign_s1;
	logic [10:0] bexp_s1;
	logic [51:0] frac_s1;
	logic [5:0]  msb_s1;
	logic        adv;

	assign adv  = !v_s1 || job_ready;
	assign full = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			sign_s1 <= value_bits[63];
			bexp_s1 <= value_bits[62:52];
			frac_s1 <= value_bits[51:0];
			msb_s1  <= lead_pos(value_bits[51:0]);
		end
	end

	logic [63:0]       sig;
	logic [63:0]       mant;
	logic signed [12:0] ilog;
	logic [3:0]        mlen;
	logic signed [15:0] expo;

	always_comb begin
		job = '0;
		sig = {12'd0, frac_s1};
		if (bexp_s1 == '0) begin
			mant = sig << (7'd63 - {1'b0, msb_s1});
			ilog = 13'($signed({7'd0, msb_s1})) - 13'sd1074;
		end else begin
			mant = {1'b1, frac_s1, 11'd0};
			ilog = $signed({2'd0, bexp_s1}) - 13'sd1023;
		end
		// lowest non-zero octet sets the mantissa length
		mlen = 4'd1;
		for (int b = 6; b >= 0; b--) begin
			if (mant[b * 8 +: 8] != 8'd0) begin
				mlen = 4'(8 - b);
			end
		end
		expo = 16'(ilog) + 16'sd1 - 16'($signed({1'b0, mlen, 3'd0}));
		job.sign  = sign_s1;
		job.mant  = mant;
		job.mlen  = mlen;
		job.expo  = expo;
		job.elen2 = (expo < -16'sd128) || (expo > 16'sd127);
		if (bexp_s1 == 11'h7ff) begin
			job.kind = (frac_s1 != '0) ? K_NAN : K_INF;
		end else if (bexp_s1 == '0 && frac_s1 == '0) begin
			job.kind = K_ZERO;
		end else begin
			job.kind = K_NORMAL;
		end
	end

	assign job_valid = v_s1;
endmodule

// ----- design/brce_queue.sv -----
module brce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  brce_pkg::job_t in_job,
	output logic           out_valid,
	input  logic           out_ready,
	output brce_pkg::job_t out_job
);
	import brce_pkg::*;

	job_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_job   = slot_q[rd_q];
	assign do_wr     = in_valid && in_ready;
	assign do_rd     = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wr_q <= !wr_q;
			if (do_rd) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_q] <= in_job;
		end
	end
endmodule

// ----- design/brce_back.sv -----
module brce_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  brce_pkg::job_t job,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     octet,
	output logic           last,
	output logic           empty_res,
	output logic           invalid
);
	import brce_pkg::*;

	// idx 0 format, then exponent octets, then mantissa
	logic [3:0] idx_q;
	logic [3:0] total;
	logic [3:0] mstart;
	logic [3:0] mi;
	logic       fin;

	assign mstart = job.elen2 ? 4'd3 : 4'd2;
	assign total  = (job.kind == K_NORMAL) ? mstart + job.mlen : 4'd1;
	assign fin    = (idx_q == total - 4'd1);
	assign mi     = idx_q - mstart;

	// output register holds one octet while the next is formed
	logic       ov_q;
	logic [7:0] oct_q;
	logic       last_q, emp_q, inv_q;
	logic       load;
	logic [7:0] o;

	assign load      = job_valid && (!ov_q || pop);
	assign job_ready = load && fin;

	always_comb begin
		o = 8'd0;
		case (job.kind)
			K_INF: o = job.sign ? OCT_MINUS_INF : OCT_PLUS_INF;
			K_NORMAL: begin
				if (idx_q == 4'd0) begin
					o = FMT_BINARY | (job.sign ? FMT_SIGN : 8'd0)
						| (job.elen2 ? FMT_EXPLEN2 : 8'd0);
				end else if (idx_q == 4'd1 && job.elen2) begin
					o = job.expo[15:8];
				end else if (idx_q < mstart) begin
					o = job.expo[7:0];
				end else begin
					o = job.mant[(4'd7 - mi[2:0]) * 8 +: 8];
				end
			end
			default: o = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 4'd0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= fin ? 4'd0 : idx_q + 4'd1;
				ov_q  <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oct_q  <= o;
			last_q <= fin;
			emp_q  <= job.kind == K_ZERO;
			inv_q  <= job.kind == K_NAN;
		end
	end

	assign empty     = !ov_q;
	assign octet     = oct_q;
	assign last      = last_q;
	assign empty_res = emp_q;
	assign invalid   = inv_q;
endmodule

// ----- design/ber_real_content_encoder_top.sv -----
// binary64 in, BER REAL content octets out (base 2, F=0), one octet per
// cycle from the result register while pop is asserted. a value is 1 +
// exponent octets + mantissa octets long (1 for zero, infinity or NaN, at
// most 11), set by the octet serializer; the front registers and classifies
// the next value and a two-entry queue lets it run ahead. the first octet
// passes the front register, a queue slot and the result register.
module ber_real_content_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] value_bits,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  octet,
	output logic        last,
	output logic        empty_res,
	output logic        invalid
);
	import brce_pkg::*;

	logic f_valid, f_ready, q_valid, q_ready;
	job_t f_job, q_job;

	brce_front u_front (
		.clk, .arst_n, .push, .full, .value_bits,
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	brce_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
		.out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
	);

	brce_back u_back (
		.clk, .arst_n,
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.empty, .pop, .octet, .last, .empty_res, .invalid
	);

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(empty_res && invalid))
		else $error("zero and nan flags together");
	a_special_single: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (empty_res || invalid) |-> last && octet == 8'd0)
		else $error("special result not a single blank octet");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(octet) && $stable(last))
		else $error("waiting result changed");
endmodule
